// ===== rtl/lsmt_pkg.sv =====
// lsmt_pkg: types and constants of the lcd scanline mode timer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lsmt_pkg;

    localparam int unsigned LINE_DOTS   = 456;
    localparam int unsigned OAM_DOTS    = 80;
    localparam int unsigned XFER_DOTS   = 172;

    localparam logic [9:0] DOTS_RELOAD = 10'(LINE_DOTS);
    localparam logic [9:0] DOTS_OAM_MIN  = 10'(LINE_DOTS - OAM_DOTS);
    localparam logic [9:0] DOTS_XFER_MIN = 10'(LINE_DOTS - OAM_DOTS - XFER_DOTS);

    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    // lcd mode codes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // stat interrupt enable bit positions
    localparam int unsigned EN_HBLANK  = 0;
    localparam int unsigned EN_VBLANK  = 1;
    localparam int unsigned EN_OAM     = 2;
    localparam int unsigned EN_COMPARE = 3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STAT_IRQ_ENABLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COMPARE     = 2'd1;

    typedef struct packed {
        logic [3:0] stat_irq_enables;
        logic [7:0] line_compare;
    } t_cfg;

    typedef struct packed {
        logic [9:0] dot_counter;
        logic [7:0] line_count;
        logic [1:0] mode_bits;
        logic       compare_flag;
    } t_timer_state;

    typedef struct packed {
        logic [7:0] line_now;
        logic [1:0] mode_now;
        logic       compare_hit;
        logic       vblank_irq;
        logic       stat_irq;
        logic       draw_line;
    } t_result;

endpackage

// ===== rtl/lsmt_cfg.sv =====
// lsmt_cfg: configuration registers of the lcd scanline mode timer
// depends on lsmt_pkg
`timescale 1ns / 1ps

module lsmt_cfg import lsmt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [7:0]           i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                CFG_STAT_IRQ_ENABLES: n_cfg.stat_irq_enables = i_data[3:0];
                CFG_LINE_COMPARE:     n_cfg.line_compare     = i_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/lsmt_step.sv =====
// lsmt_step: next timer state and result for one elapsed-time update
// depends on lsmt_pkg; purely combinational
`timescale 1ns / 1ps

module lsmt_step import lsmt_pkg::*; (
    input  t_cfg         i_cfg,
    input  t_timer_state i_state,
    input  logic [7:0]   i_elapsed_cycles,
    input  logic         i_display_on,
    output t_timer_state o_state,
    output t_result      o_result
);

    logic [1:0] new_mode;
    logic       mode_irq_en;
    logic       line_match;
    logic       expired;
    logic [7:0] line_inc;
    logic [9:0] elapsed_ext;

    assign elapsed_ext = {2'b00, i_elapsed_cycles};
    assign line_inc    = i_state.line_count + 8'd1;
    assign line_match  = (i_state.line_count == i_cfg.line_compare);
    assign expired     = (elapsed_ext >= i_state.dot_counter);

    // mode from the counter as it stood before the update
    always_comb begin
        if (i_state.line_count >= VBLANK_LINE) begin
            new_mode    = MODE_VBLANK;
            mode_irq_en = i_cfg.stat_irq_enables[EN_VBLANK];
        end else if (i_state.dot_counter >= DOTS_OAM_MIN) begin
            new_mode    = MODE_OAM;
            mode_irq_en = i_cfg.stat_irq_enables[EN_OAM];
        end else if (i_state.dot_counter >= DOTS_XFER_MIN) begin
            new_mode    = MODE_XFER;
            mode_irq_en = 1'b0;
        end else begin
            new_mode    = MODE_HBLANK;
            mode_irq_en = i_cfg.stat_irq_enables[EN_HBLANK];
        end
    end

    always_comb begin
        o_state             = i_state;
        o_result.vblank_irq = 1'b0;
        o_result.stat_irq   = 1'b0;
        o_result.draw_line  = 1'b0;
        if (!i_display_on) begin
            o_state.dot_counter = DOTS_RELOAD;
            o_state.line_count  = '0;
            o_state.mode_bits   = MODE_VBLANK;
        end else begin
            o_state.mode_bits    = new_mode;
            o_state.compare_flag = line_match;
            o_result.stat_irq    = (mode_irq_en && (new_mode != i_state.mode_bits))
                                 || (line_match && i_cfg.stat_irq_enables[EN_COMPARE]);
            if (expired) begin
                o_state.dot_counter = DOTS_RELOAD;
                if (line_inc < VBLANK_LINE) begin
                    o_state.line_count = line_inc;
                    o_result.draw_line = 1'b1;
                end else if (line_inc == VBLANK_LINE) begin
                    o_state.line_count  = line_inc;
                    o_result.vblank_irq = 1'b1;
                end else if (line_inc > LAST_LINE) begin
                    o_state.line_count = '0;
                end else begin
                    o_state.line_count = line_inc;
                end
            end else begin
                o_state.dot_counter = i_state.dot_counter - elapsed_ext;
            end
        end
        o_result.line_now    = o_state.line_count;
        o_result.mode_now    = o_state.mode_bits;
        o_result.compare_hit = o_state.compare_flag;
    end

endmodule

// ===== rtl/lcd_scanline_mode_timer.sv =====
// lcd_scanline_mode_timer: top level of the lcd mode and scanline timer
// depends on lsmt_pkg, lsmt_cfg and lsmt_step
`timescale 1ns / 1ps

// usage
// - input channel: i_valid / o_stall carry one elapsed-time update
//   (i_elapsed_cycles, i_display_on); a transfer happens when i_valid is high
//   and o_stall is low
// - output channel: o_valid / i_stall carry one result per update (line,
//   mode, compare flag and the vblank, stat and draw pulses)
// - config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; index 0 is the stat interrupt enables, index 1 the compare line;
//   o_cfg_ready is always high, writes are expected only while the block is idle
// - path: an input transfer goes to the input register, then to the result
//   register, with the timer state updated alongside the result
// - throughput: one update per cycle while the receiver does not stall, set
//   by the combinational compare and subtract on the self-fed dot counter
// - reset (i_rst_n low, synchronous): counter 456, line 0, mode 0, compare
//   flag 0, config registers 0, both stages empty
// - when the receiver stalls, the result register holds; the input register
//   still takes one update, and o_stall rises only once both stages are full

module lcd_scanline_mode_timer import lsmt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // update input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_elapsed_cycles,
    input  logic                 i_display_on,
    // result output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_line_now,
    output logic [1:0]           o_mode_now,
    output logic                 o_compare_hit,
    output logic                 o_vblank_irq,
    output logic                 o_stat_irq,
    output logic                 o_draw_line,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg cfg;

    // input register stage
    logic       r_in_valid;
    logic [7:0] r_elapsed_cycles;
    logic       r_display_on;

    // timer state and result register
    t_timer_state r_state;
    t_timer_state n_state;
    t_result      r_result;
    t_result      n_result;
    logic         r_out_valid;

    logic in_xfer;
    logic out_free;
    logic step_go;

    assign o_cfg_ready = 1'b1;

    lsmt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // result register can take a new value when empty or being drained
    assign out_free = !r_out_valid || !i_stall;
    assign step_go  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_xfer  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_elapsed_cycles <= i_elapsed_cycles;
            r_display_on     <= i_display_on;
        end
    end

    lsmt_step u_step (
        .i_cfg            (cfg),
        .i_state          (r_state),
        .i_elapsed_cycles (r_elapsed_cycles),
        .i_display_on     (r_display_on),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    // timer state advances exactly once per update, as the result is captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.dot_counter  <= DOTS_RELOAD;
            r_state.line_count   <= '0;
            r_state.mode_bits    <= MODE_HBLANK;
            r_state.compare_flag <= 1'b0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_line_now    = r_result.line_now;
    assign o_mode_now    = r_result.mode_now;
    assign o_compare_hit = r_result.compare_hit;
    assign o_vblank_irq  = r_result.vblank_irq;
    assign o_stat_irq    = r_result.stat_irq;
    assign o_draw_line   = r_result.draw_line;

endmodule

// ===== rtl/lsmt_checker.sv =====
// lsmt_checker: port-level assertions for lcd_scanline_mode_timer
// depends on lsmt_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module lsmt_checker import lsmt_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_line_now,
    input logic       o_vblank_irq,
    input logic       o_draw_line
);

    // line never leaves the frame
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_line_now <= LAST_LINE))
        else $error("line out of range");

    // a draw pulse always names a visible line
    a_draw_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_draw_line) |-> (o_line_now < VBLANK_LINE))
        else $error("draw pulse on non-visible line");

    // vblank pulse only as line 144 starts, never together with draw
    a_vblank_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vblank_irq) |-> (o_line_now == VBLANK_LINE && !o_draw_line))
        else $error("vblank pulse on wrong line");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_line_now)))
        else $error("stalled result changed");

endmodule

bind lcd_scanline_mode_timer lsmt_checker u_lsmt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_line_now   (o_line_now),
    .o_vblank_irq (o_vblank_irq),
    .o_draw_line  (o_draw_line)
);
